/* sv/fgce_pkg.sv */
`timescale 1ns / 1ps

package fgce_pkg;

   // Register file contents as seen by the datapath
   typedef struct packed {
      logic [10:0] store_width;
      logic [10:0] store_height;
      logic [1:0]  buffer_layout;
   } csr_type;

   // One draw-character request as it arrives
   typedef struct packed {
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [7:0]         char_code;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [3:0]         scale;
   } req_type;

   // Decoded request: glyph cells in scan order, top-left cell in bit 34
   typedef struct packed {
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [34:0]        cells;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [3:0]         scale;
   } job_type;

   // One output square
   typedef struct packed {
      logic [9:0] col_start;
      logic [9:0] row_start;
      logic [3:0] col_count;
      logic [3:0] row_count;
      logic [7:0] byte_first;
      logic [7:0] byte_middle;
      logic [7:0] byte_last;
      logic       last_square;
   } rsp_type;

   // 5x7 font: seven 5-bit rows, top row in the high bits, bit 4 leftmost
   function automatic logic [34:0] glyph_bits(input logic [7:0] code);
      logic [34:0] g;
      unique case (code)
         8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}; // 0
         8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
         8'h33: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
         8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
         8'h35: g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
         8'h36: g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
         8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
         8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
         8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C}; // 9
         8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}; // A
         8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
         8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
         8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
         8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
         8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
         8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
         8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
         8'h49: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
         8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
         8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
         8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
         8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
         8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
         8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
         8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
         8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
         8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
         8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
         8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
         8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
         8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
         8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}; // Z
         8'h61: g = {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F}; // a
         8'h62: g = {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h1E};
         8'h63: g = {5'h00,5'h00,5'h0E,5'h10,5'h10,5'h11,5'h0E};
         8'h64: g = {5'h01,5'h01,5'h0D,5'h13,5'h11,5'h11,5'h0F};
         8'h65: g = {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E};
         8'h66: g = {5'h06,5'h08,5'h08,5'h1C,5'h08,5'h08,5'h08};
         8'h67: g = {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E};
         8'h68: g = {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11};
         8'h69: g = {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E};
         8'h6A: g = {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C};
         8'h6B: g = {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12};
         8'h6C: g = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h6D: g = {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15};
         8'h6E: g = {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11};
         8'h6F: g = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E};
         8'h70: g = {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10};
         8'h71: g = {5'h00,5'h00,5'h0D,5'h13,5'h0F,5'h01,5'h01};
         8'h72: g = {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10};
         8'h73: g = {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E};
         8'h74: g = {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06};
         8'h75: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D};
         8'h76: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04};
         8'h77: g = {5'h00,5'h00,5'h11,5'h15,5'h15,5'h15,5'h0A};
         8'h78: g = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11};
         8'h79: g = {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         8'h7A: g = {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F}; // z
         8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}; // minus
         8'h3A: g = {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00}; // colon
         8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C}; // period
         8'h2F: g = {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10}; // slash
         8'h3C: g = {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02}; // less than
         8'h3E: g = {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08}; // greater than
         8'h5B: g = {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E}; // open bracket
         8'h5D: g = {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E}; // close bracket
         8'h5F: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F}; // underscore
         8'h21: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04}; // exclamation
         8'h3F: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04}; // question
         8'h2C: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08}; // comma
         8'h27: g = {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00}; // apostrophe
         8'h22: g = {5'h0A,5'h0A,5'h14,5'h00,5'h00,5'h00,5'h00}; // double quote
         8'h23: g = {5'h0A,5'h1F,5'h0A,5'h0A,5'h1F,5'h0A,5'h00}; // hash
         8'h25: g = {5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13}; // percent
         8'h26: g = {5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D}; // ampersand
         8'h28: g = {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}; // open paren
         8'h29: g = {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08}; // close paren
         8'h2A: g = {5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00}; // asterisk
         8'h2B: g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00}; // plus
         8'h3D: g = {5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00}; // equals
         8'h40: g = {5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E}; // at sign
         8'h7C: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}; // bar
         8'h20: g = '0;                                            // space
         default: g = {5'h1F,5'h11,5'h15,5'h15,5'h11,5'h11,5'h1F}; // box
      endcase
      return g;
   endfunction

endpackage

/* sv/fgce_front.sv */
`timescale 1ns / 1ps

module fgce_front import fgce_pkg::*; #(
   parameter int MAX_SCALE = 15
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   input  logic    q_ready,
   output logic    q_push,
   output job_type q_item
);

   logic    valid_ff, valid_in;
   job_type item_ff, item_in;
   logic    accept;
   logic [3:0] scale_fix;

   // Take a beat whenever the stage is empty or drains into the queue this cycle
   assign req_ready = !valid_ff || q_ready;
   assign accept    = req_valid && req_ready;
   assign q_push    = valid_ff && q_ready;
   assign q_item    = item_ff;

   // Clamp scale: zero counts as one, large values saturate
   always_comb begin
      scale_fix = (req_item.scale == 4'd0) ? 4'd1 : req_item.scale;
      if (32'(scale_fix) > $unsigned(MAX_SCALE)) begin
         scale_fix = 4'(MAX_SCALE);
      end
   end

   // Decode the request into glyph cells
   always_comb begin
      item_in.pos_x = req_item.pos_x;
      item_in.pos_y = req_item.pos_y;
      item_in.cells = glyph_bits(req_item.char_code);
      item_in.red   = req_item.red;
      item_in.green = req_item.green;
      item_in.blue  = req_item.blue;
      item_in.scale = scale_fix;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* sv/fgce_queue.sv */
`timescale 1ns / 1ps

module fgce_queue import fgce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_item,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_item
);

   localparam int DEPTH = 2;

   job_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/fgce_back.sv */
`timescale 1ns / 1ps

module fgce_back import fgce_pkg::*; #(
   parameter int MAX_DIM = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    job_valid,
   input  job_type job_item,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CW    = (DIM_W + 2 > 14) ? DIM_W + 2 : 14;

   localparam logic [1:0] LAYOUT_RGB     = 2'd0;
   localparam logic [1:0] LAYOUT_BGR_ROT = 2'd2;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_type;

   state_type state_ff, state_in;
   logic [34:0] cells_ff, cells_in;
   logic [2:0]  gx_ff, gx_in;
   logic signed [CW-1:0] px_ff, px_in;
   logic signed [CW-1:0] x0_ff, x0_in;
   logic signed [CW-1:0] y0_ff, y0_in;
   logic [3:0]  scale_ff, scale_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic        pend_valid_ff, pend_valid_in;
   rsp_type     pend_ff, pend_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic signed [CW-1:0] sw, sh, lw, lh, sw_ext, sh_ext, dim_max, s_ext;
   logic signed [CW-1:0] x_end, y_end, xs, ys, xe, ye, dx, dy, col_rot;
   logic        rotated, rgb, visible, cell_hit, out_free, emit, emit_last;
   rsp_type     cur;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // Logical screen size after clamping the store dimensions
   always_comb begin
      sw_ext  = $signed(CW'(csr.store_width));
      sh_ext  = $signed(CW'(csr.store_height));
      dim_max = CW'(MAX_DIM);
      sw      = (sw_ext > dim_max) ? dim_max : sw_ext;
      sh      = (sh_ext > dim_max) ? dim_max : sh_ext;
      rotated = (csr.buffer_layout == LAYOUT_BGR_ROT);
      rgb     = (csr.buffer_layout == LAYOUT_RGB);
      lw      = rotated ? sh : sw;
      lh      = rotated ? sw : sh;
   end

   // Clip the current cell's square and map it to storage
   always_comb begin
      s_ext   = $signed(CW'(scale_ff));
      x_end   = x0_ff + s_ext;
      y_end   = y0_ff + s_ext;
      xs      = x0_ff[CW-1] ? '0 : x0_ff;
      ys      = y0_ff[CW-1] ? '0 : y0_ff;
      xe      = (x_end > lw) ? lw : x_end;
      ye      = (y_end > lh) ? lh : y_end;
      visible = (xs < xe) && (ys < ye);
      dx      = xe - xs;
      dy      = ye - ys;
      col_rot = sw - ye;
      if (rotated) begin
         cur.col_start = col_rot[9:0];
         cur.row_start = xs[9:0];
         cur.col_count = dy[3:0];
         cur.row_count = dx[3:0];
      end else begin
         cur.col_start = xs[9:0];
         cur.row_start = ys[9:0];
         cur.col_count = dx[3:0];
         cur.row_count = dy[3:0];
      end
      cur.byte_first  = rgb ? red_ff : blue_ff;
      cur.byte_middle = green_ff;
      cur.byte_last   = rgb ? blue_ff : red_ff;
      cur.last_square = 1'b0;
   end

   // Sequencer: one cell per cycle unless stalled; holds one square to mark the last
   always_comb begin
      state_in      = state_ff;
      cells_in      = cells_ff;
      gx_in         = gx_ff;
      px_in         = px_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      scale_in      = scale_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      job_pop       = 1'b0;
      emit          = 1'b0;
      emit_last     = 1'b0;
      out_free      = !out_valid_ff || rsp_ready;
      cell_hit      = cells_ff[34] && visible;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               cells_in = job_item.cells;
               gx_in    = 3'd0;
               px_in    = {{(CW-12){job_item.pos_x[11]}}, job_item.pos_x};
               x0_in    = {{(CW-12){job_item.pos_x[11]}}, job_item.pos_x};
               y0_in    = {{(CW-12){job_item.pos_y[11]}}, job_item.pos_y};
               scale_in = job_item.scale;
               red_in   = job_item.red;
               green_in = job_item.green;
               blue_in  = job_item.blue;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // hold while a new square would push out the held one into a full output
            if (!(cell_hit && pend_valid_ff && !out_free)) begin
               if (cell_hit) begin
                  emit          = pend_valid_ff;
                  pend_in       = cur;
                  pend_valid_in = 1'b1;
               end
               cells_in = {cells_ff[33:0], 1'b0};
               if (gx_ff == 3'd4) begin
                  gx_in = 3'd0;
                  x0_in = px_ff;
                  y0_in = y0_ff + s_ext;
               end else begin
                  gx_in = gx_ff + 3'd1;
                  x0_in = x0_ff + s_ext;
               end
               if (cells_in == '0) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit          = 1'b1;
               emit_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Output register
      out_in = out_ff;
      if (emit) begin
         out_valid_in       = 1'b1;
         out_in             = pend_ff;
         out_in.last_square = emit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cells_ff <= cells_in;
      gx_ff    <= gx_in;
      px_ff    <= px_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      scale_ff <= scale_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

endmodule

/* sv/font_glyph_cell_expander_core.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// req_     | in        | tvalid / tready        | tdata: one draw-character request
// rsp_     | out       | tvalid / tready, tlast | tdata: one square, tlast marks last square
// csr_     | in        | APB, pready tied high  | store_width, store_height, buffer_layout
//
// The back end walks the 35 glyph cells one per clock unless a stall on rsp_ holds it,
// and stops after the last lit cell: it loads a character, scans its cells and then
// releases the held final square.
// Reset is synchronous; it clears control state and restores the register defaults.
// A stall on rsp_ holds the cell sequencer; the front stage and a 2-entry queue keep
// accepting up to three more requests meanwhile.

module font_glyph_cell_expander_core import fgce_pkg::*; #(
   parameter int MAX_DIM   = 1024,
   parameter int MAX_SCALE = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[11:0], pos_y[23:12], char_code[31:24], red[39:32], green[47:40],
   // blue[55:48], scale[59:56], zero[63:60]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // col_start[9:0], row_start[19:10], col_count[23:20], row_count[27:24],
   // byte_first[35:28], byte_middle[43:36], byte_last[51:44], zero[55:52]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] REG_STORE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_STORE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_BUFFER_LAYOUT = 2'd2;

   csr_type csr_ff, csr_in;
   logic    csr_write;
   req_type req_item;
   job_type front_item, queue_item;
   logic    front_push, queue_ready, queue_valid, queue_pop;
   rsp_type rsp_item;

   // Register file writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_STORE_WIDTH:   csr_in.store_width   = csr_pwdata[10:0];
            REG_STORE_HEIGHT:  csr_in.store_height  = csr_pwdata[10:0];
            REG_BUFFER_LAYOUT: csr_in.buffer_layout = csr_pwdata[1:0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.store_width   <= 11'd400;
         csr_ff.store_height  <= 11'd240;
         csr_ff.buffer_layout <= 2'd0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_STORE_WIDTH:   csr_prdata = {21'd0, csr_ff.store_width};
         REG_STORE_HEIGHT:  csr_prdata = {21'd0, csr_ff.store_height};
         REG_BUFFER_LAYOUT: csr_prdata = {30'd0, csr_ff.buffer_layout};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Unpack the request beat
   always_comb begin
      req_item.pos_x     = $signed(req_tdata[11:0]);
      req_item.pos_y     = $signed(req_tdata[23:12]);
      req_item.char_code = req_tdata[31:24];
      req_item.red       = req_tdata[39:32];
      req_item.green     = req_tdata[47:40];
      req_item.blue      = req_tdata[55:48];
      req_item.scale     = req_tdata[59:56];
   end

   fgce_front #(
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .q_ready   (queue_ready),
      .q_push    (front_push),
      .q_item    (front_item)
   );

   fgce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item)
   );

   fgce_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .job_valid (queue_valid),
      .job_item  (queue_item),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // Pack the result beat
   assign rsp_tdata = {4'd0, rsp_item.byte_last, rsp_item.byte_middle, rsp_item.byte_first,
                       rsp_item.row_count, rsp_item.col_count,
                       rsp_item.row_start, rsp_item.col_start};
   assign rsp_tlast = rsp_item.last_square;

endmodule

/* sim/tb_font_glyph_cell_expander_core.sv */
`timescale 1ns / 1ps

module tb_font_glyph_cell_expander_core;
   import fgce_pkg::*;

   localparam int MAX_DIM       = 1024;
   localparam int SETTLE_CYCLES = 160;
   localparam int QUIET_LIMIT   = 2000;
   localparam int UNTYPED       = -1;
   localparam int RANDOM_DIM    = -1;

   localparam logic [3:0] ADDR_STORE_WIDTH   = 4'h0;
   localparam logic [3:0] ADDR_STORE_HEIGHT  = 4'h4;
   localparam logic [3:0] ADDR_BUFFER_LAYOUT = 4'h8;

   localparam logic [1:0] LAYOUT_RGB     = 2'd0;
   localparam logic [1:0] LAYOUT_BGR     = 2'd1;
   localparam logic [1:0] LAYOUT_ROTATED = 2'd2;
   localparam logic [1:0] LAYOUT_SPARE   = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [34:0] BOX_GLYPH = {5'h1F,5'h11,5'h15,5'h15,5'h11,5'h11,5'h1F};

   // receiver stall patterns
   localparam int READY_ALWAYS   = 0;
   localparam int READY_MOSTLY   = 1;
   localparam int READY_PERIODIC = 2;
   localparam int READY_RARELY   = 3;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // pos_x[11:0], pos_y[23:12], char_code[31:24], red[39:32], green[47:40],
   // blue[55:48], scale[59:56], zero[63:60]
   logic [63:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // col_start[9:0], row_start[19:10], col_count[23:20], row_count[27:24],
   // byte_first[35:28], byte_middle[43:36], byte_last[51:44], zero[55:52]
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   font_glyph_cell_expander_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   typedef struct {
      int         x;
      int         y;
      logic [7:0] code;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] scale;
      int         squares;
   } directed_row_t;

   typedef struct {
      int         width;
      int         height;
      logic [1:0] layout;
      int         items;
   } setting_row_t;

   // mirror of the register file
   logic [10:0] width_setting  = 11'd400;
   logic [10:0] height_setting = 11'd240;
   logic [1:0]  layout_setting = LAYOUT_RGB;

   logic [4:0] font_rows [256][7];
   rsp_type    squares_due [$];

   int fail_count       = 0;
   int requests_sent    = 0;
   int squares_checked  = 0;
   int settings_applied = 0;
   int burst_left       = 0;
   int stall_mode       = READY_ALWAYS;
   int stall_left       = 0;

   // directed stimulus at the reset setting: 400 x 240, rgb
   directed_row_t directed_rows [24] = '{
      '{0,     0,     "0",        8'h00, 8'hFF, 8'h55, 4'd1,  UNTYPED},
      '{10,    10,    CHAR_SPACE, 8'hFF, 8'hFF, 8'hFF, 4'd3,  0},
      '{0,     0,     8'hFF,      8'h12, 8'h34, 8'h56, 4'd0,  22},
      '{100,   100,   8'h80,      8'hAA, 8'h55, 8'hAA, 4'd1,  22},
      '{200,   20,    8'h00,      8'h01, 8'h02, 8'h03, 4'd2,  22},
      '{-2048, -2048, "W",        8'hFF, 8'hFF, 8'hFF, 4'd15, 0},
      '{2047,  2047,  "M",        8'h00, 8'h00, 8'h00, 4'd15, 0},
      '{-2048, 100,   "H",        8'h11, 8'h22, 8'h33, 4'd15, 0},
      '{100,   2047,  "H",        8'h44, 8'h55, 8'h66, 4'd1,  0},
      '{-7,    -9,    "A",        8'h80, 8'h7F, 8'h01, 4'd4,  UNTYPED},
      '{395,   235,   "W",        8'h0F, 8'hF0, 8'h3C, 4'd2,  UNTYPED},
      '{392,   230,   "@",        8'hC3, 8'h5A, 8'hA5, 4'd15, UNTYPED},
      '{100,   50,    "@",        8'h01, 8'h80, 8'hFE, 4'd15, UNTYPED},
      '{-1,    -1,    "#",        8'h10, 8'h20, 8'h40, 4'd1,  UNTYPED},
      '{20,    20,    "*",        8'h08, 8'h04, 8'h02, 4'd3,  UNTYPED},
      '{30,    30,    "_",        8'h7E, 8'hE7, 8'h81, 4'd1,  5},
      '{40,    40,    8'h27,      8'h99, 8'h66, 8'h33, 4'd1,  UNTYPED},
      '{50,    40,    8'h22,      8'hDE, 8'hAD, 8'hBE, 4'd2,  UNTYPED},
      '{60,    60,    "j",        8'hEF, 8'hBE, 8'hAD, 4'd5,  UNTYPED},
      '{-5,    3,     ".",        8'h55, 8'hAA, 8'h55, 4'd1,  0},
      '{399,   239,   "|",        8'hFF, 8'h00, 8'hFF, 4'd1,  0},
      '{397,   0,     "|",        8'h00, 8'hFF, 8'h00, 4'd1,  7},
      '{0,     0,     "8",        8'hFF, 8'h00, 8'hFF, 4'd15, UNTYPED},
      '{1000,  -2000, "Z",        8'h12, 8'h34, 8'h56, 4'd7,  0}
   };

   // register settings walked by the random part
   setting_row_t setting_rows [10] = '{
      '{400,        240,        LAYOUT_BGR,     23},
      '{400,        240,        LAYOUT_ROTATED, 23},
      '{1024,       1024,       LAYOUT_ROTATED, 23},
      '{2047,       1500,       LAYOUT_RGB,     23},
      '{1,          1,          LAYOUT_SPARE,   23},
      '{0,          240,        LAYOUT_RGB,     8},
      '{320,        0,          LAYOUT_ROTATED, 8},
      '{1024,       768,        LAYOUT_SPARE,   23},
      '{17,         9,          LAYOUT_ROTATED, 23},
      '{RANDOM_DIM, RANDOM_DIM, LAYOUT_RGB,     23}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // store one glyph, top row in the high bits
   task automatic set_glyph(input logic [7:0] code, input logic [34:0] bits);
      for (int gy = 0; gy < 7; gy++) font_rows[code][gy] = bits[34 - 5*gy -: 5];
   endtask

   task automatic load_font();
      for (int c = 0; c < 256; c++) set_glyph(8'(c), BOX_GLYPH);
      set_glyph("0", {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E});
      set_glyph("1", {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E});
      set_glyph("2", {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F});
      set_glyph("3", {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E});
      set_glyph("4", {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02});
      set_glyph("5", {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E});
      set_glyph("6", {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E});
      set_glyph("7", {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08});
      set_glyph("8", {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E});
      set_glyph("9", {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C});
      set_glyph("A", {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11});
      set_glyph("B", {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E});
      set_glyph("C", {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E});
      set_glyph("D", {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E});
      set_glyph("E", {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F});
      set_glyph("F", {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10});
      set_glyph("G", {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F});
      set_glyph("H", {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11});
      set_glyph("I", {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E});
      set_glyph("J", {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C});
      set_glyph("K", {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11});
      set_glyph("L", {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F});
      set_glyph("M", {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11});
      set_glyph("N", {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11});
      set_glyph("O", {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E});
      set_glyph("P", {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10});
      set_glyph("Q", {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D});
      set_glyph("R", {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11});
      set_glyph("S", {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E});
      set_glyph("T", {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04});
      set_glyph("U", {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E});
      set_glyph("V", {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04});
      set_glyph("W", {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A});
      set_glyph("X", {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11});
      set_glyph("Y", {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04});
      set_glyph("Z", {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F});
      set_glyph("a", {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F});
      set_glyph("b", {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h1E});
      set_glyph("c", {5'h00,5'h00,5'h0E,5'h10,5'h10,5'h11,5'h0E});
      set_glyph("d", {5'h01,5'h01,5'h0D,5'h13,5'h11,5'h11,5'h0F});
      set_glyph("e", {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E});
      set_glyph("f", {5'h06,5'h08,5'h08,5'h1C,5'h08,5'h08,5'h08});
      set_glyph("g", {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E});
      set_glyph("h", {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11});
      set_glyph("i", {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E});
      set_glyph("j", {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C});
      set_glyph("k", {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12});
      set_glyph("l", {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E});
      set_glyph("m", {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15});
      set_glyph("n", {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11});
      set_glyph("o", {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E});
      set_glyph("p", {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10});
      set_glyph("q", {5'h00,5'h00,5'h0D,5'h13,5'h0F,5'h01,5'h01});
      set_glyph("r", {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10});
      set_glyph("s", {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E});
      set_glyph("t", {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06});
      set_glyph("u", {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D});
      set_glyph("v", {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04});
      set_glyph("w", {5'h00,5'h00,5'h11,5'h15,5'h15,5'h15,5'h0A});
      set_glyph("x", {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11});
      set_glyph("y", {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E});
      set_glyph("z", {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F});
      set_glyph("-", {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00});
      set_glyph(":", {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00});
      set_glyph(".", {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C});
      set_glyph("/", {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10});
      set_glyph("<", {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02});
      set_glyph(">", {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08});
      set_glyph("[", {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E});
      set_glyph("]", {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E});
      set_glyph("_", {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F});
      set_glyph("!", {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04});
      set_glyph("?", {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04});
      set_glyph(",", {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08});
      set_glyph(8'h27, {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00});
      set_glyph(8'h22, {5'h0A,5'h0A,5'h14,5'h00,5'h00,5'h00,5'h00});
      set_glyph("#", {5'h0A,5'h1F,5'h0A,5'h0A,5'h1F,5'h0A,5'h00});
      set_glyph("%", {5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13});
      set_glyph("&", {5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D});
      set_glyph("(", {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02});
      set_glyph(")", {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08});
      set_glyph("*", {5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00});
      set_glyph("+", {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00});
      set_glyph("=", {5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00});
      set_glyph("@", {5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E});
      set_glyph("|", {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04});
      set_glyph(CHAR_SPACE, 35'h0);
   endtask

   function automatic int clamp_dim(input logic [10:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic int pick(input int lo, input int hi);
      return (hi <= lo) ? lo : lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // expand one request into the squares it should produce; returns their number
   function automatic int predict_squares(input req_type r);
      int px, py, s, sw, sh, lw, lh, x0, y0, xs, ys, xe, ye, n;
      bit rotated, rgb, held;
      rsp_type sq, prev;
      px = $signed(r.pos_x);
      py = $signed(r.pos_y);
      s = (r.scale == 0) ? 1 : int'(r.scale);
      sw = clamp_dim(width_setting);
      sh = clamp_dim(height_setting);
      rotated = (layout_setting == LAYOUT_ROTATED);
      rgb = (layout_setting == LAYOUT_RGB);
      lw = rotated ? sh : sw;
      lh = rotated ? sw : sh;
      n = 0;
      held = 1'b0;
      prev = '0;
      for (int gy = 0; gy < 7; gy++) begin
         for (int gx = 0; gx < 5; gx++) begin
            if (!font_rows[r.char_code][gy][4 - gx]) continue;
            x0 = px + gx * s;
            y0 = py + gy * s;
            xs = (x0 < 0) ? 0 : x0;
            ys = (y0 < 0) ? 0 : y0;
            xe = (x0 + s > lw) ? lw : x0 + s;
            ye = (y0 + s > lh) ? lh : y0 + s;
            // drop cells clipped away completely
            if (xs >= xe || ys >= ye) continue;
            if (rotated) begin
               sq.col_start = 10'(sw - ye);
               sq.row_start = 10'(xs);
               sq.col_count = 4'(ye - ys);
               sq.row_count = 4'(xe - xs);
            end else begin
               sq.col_start = 10'(xs);
               sq.row_start = 10'(ys);
               sq.col_count = 4'(xe - xs);
               sq.row_count = 4'(ye - ys);
            end
            sq.byte_first  = rgb ? r.red : r.blue;
            sq.byte_middle = r.green;
            sq.byte_last   = rgb ? r.blue : r.red;
            sq.last_square = 1'b0;
            // hold one square back so the final one can be marked
            if (held) squares_due.push_back(prev);
            prev = sq;
            held = 1'b1;
            n++;
         end
      end
      if (held) begin
         prev.last_square = 1'b1;
         squares_due.push_back(prev);
      end
      return n;
   endfunction

   // place a coordinate mostly on screen and around its edges
   function automatic logic [11:0] place_coord(input int extent, input int s);
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 4095));
         1: v = pick(-7 * s, 0);
         2: v = pick(extent - 7 * s, extent);
         default: v = (extent > 0) ? pick(-s, extent - 1) : pick(-20, 20);
      endcase
      return v[11:0];
   endfunction

   function automatic req_type random_request();
      req_type r;
      int s, sw, sh;
      bit rotated;
      r.scale = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 4));
      s = (r.scale == 0) ? 1 : int'(r.scale);
      sw = clamp_dim(width_setting);
      sh = clamp_dim(height_setting);
      rotated = (layout_setting == LAYOUT_ROTATED);
      r.pos_x = place_coord(rotated ? sh : sw, s);
      r.pos_y = place_coord(rotated ? sw : sh, s);
      case ($urandom_range(0, 9))
         0: r.char_code = 8'($urandom_range(0, 255));
         1: r.char_code = CHAR_SPACE;
         default: r.char_code = 8'($urandom_range(8'h21, 8'h7E));
      endcase
      r.red   = 8'($urandom_range(0, 255));
      r.green = 8'($urandom_range(0, 255));
      r.blue  = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // present one request, predict on acceptance, then maybe idle
   task automatic push_request(input req_type r, output int n);
      req_tdata  <= {4'b0, r.scale, r.blue, r.green, r.red, r.char_code, r.pos_y, r.pos_x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      n = predict_squares(r);
      requests_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : int'($urandom_range(1, 12));
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // hold the sender until every predicted square has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (squares_due.size() != 0) @(posedge clock);
   endtask

   // let requests that produce nothing finish too
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic csr_write(input logic [3:0] addr, input logic [10:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (addr)
         ADDR_STORE_WIDTH:  width_setting  = value;
         ADDR_STORE_HEIGHT: height_setting = value;
         default:           layout_setting = value[1:0];
      endcase
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (addr)
         ADDR_STORE_WIDTH:  check_field("store_width", width_setting, readback[10:0]);
         ADDR_STORE_HEIGHT: check_field("store_height", height_setting, readback[10:0]);
         default:           check_field("buffer_layout", layout_setting, readback[1:0]);
      endcase
   endtask

   // receiver: switch between stall patterns every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(READY_ALWAYS, READY_RARELY);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_tready <= ((stall_left % 4) != 0);
         default:        rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // compare every square beat with the oldest prediction
   always @(posedge clock) begin : square_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (squares_due.size() == 0) begin
            $error("square beat with no prediction pending");
            fail_count++;
         end else begin
            want = squares_due.pop_front();
            squares_checked++;
            check_field("col_start", want.col_start, rsp_tdata[9:0]);
            check_field("row_start", want.row_start, rsp_tdata[19:10]);
            check_field("col_count", want.col_count, rsp_tdata[23:20]);
            check_field("row_count", want.row_count, rsp_tdata[27:24]);
            check_field("byte_first", want.byte_first, rsp_tdata[35:28]);
            check_field("byte_middle", want.byte_middle, rsp_tdata[43:36]);
            check_field("byte_last", want.byte_last, rsp_tdata[51:44]);
            check_field("last_square", want.last_square, rsp_tlast);
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout after %0d quiet cycles, %0d squares outstanding",
               QUIET_LIMIT, squares_due.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      int n, w, h;
      logic [1:0] layout;
      load_font();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset setting
      foreach (directed_rows[i]) begin
         r.pos_x     = directed_rows[i].x[11:0];
         r.pos_y     = directed_rows[i].y[11:0];
         r.char_code = directed_rows[i].code;
         r.red       = directed_rows[i].red;
         r.green     = directed_rows[i].green;
         r.blue      = directed_rows[i].blue;
         r.scale     = directed_rows[i].scale;
         push_request(r, n);
         if (directed_rows[i].squares != UNTYPED)
            check_field("squares per character", directed_rows[i].squares, n);
      end

      // random requests under each register setting
      foreach (setting_rows[p]) begin
         settle();
         w = setting_rows[p].width;
         h = setting_rows[p].height;
         layout = setting_rows[p].layout;
         if (w == RANDOM_DIM) begin
            w = $urandom_range(0, 2047);
            h = $urandom_range(0, 2047);
            layout = 2'($urandom_range(0, 3));
         end
         csr_write(ADDR_STORE_WIDTH, 11'(w));
         csr_write(ADDR_STORE_HEIGHT, 11'(h));
         csr_write(ADDR_BUFFER_LAYOUT, 11'(layout));
         settings_applied++;
         for (int k = 0; k < setting_rows[p].items; k++) begin
            if (k == setting_rows[p].items / 2) wait_drained();
            push_request(random_request(), n);
         end
      end

      settle();
      $display("Sent %0d draw requests and checked %0d squares", requests_sent, squares_checked);
      $display("Covered %0d register settings after the reset one", settings_applied);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
